// ===== src/iscc_pkg.sv =====
// Shared types and constants for the insertion sorter with comparison count.
// Used by the sort cell and the core; no dependencies.
package iscc_pkg;

  localparam int SUM_W = 9;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic load;
    logic drain;
  } cell_ctrl_t;

endpackage

// ===== src/iscc_cell.sv =====
// One compare-and-shift cell of the sort chain: holds one stored value.
// Depends on iscc_pkg for the control struct.
module iscc_cell import iscc_pkg::*; #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  cell_ctrl_t                    ctrl_i,
  input  logic                          occ_i,
  input  logic                          at_fill_i,
  input  logic signed [VALUE_WIDTH-1:0] sample_i,
  input  logic signed [VALUE_WIDTH-1:0] prev_val_i,
  input  logic                          prev_gt_i,
  input  logic signed [VALUE_WIDTH-1:0] next_val_i,
  output logic signed [VALUE_WIDTH-1:0] val_o,
  output logic                          gt_o,
  output logic                          ins_o
);

  logic signed [VALUE_WIDTH-1:0] val_q, val_d;
  logic                          move;

  assign gt_o  = occ_i && (val_q > sample_i);
  assign move  = occ_i ? gt_o : at_fill_i;
  assign ins_o = move && !prev_gt_i;
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.drain) begin
      val_d = next_val_i;
    end else if (ctrl_i.load && move) begin
      val_d = prev_gt_i ? prev_val_i : sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== src/insertion_sorter_with_comparison_count_core.sv =====
// Insertion sorter with comparison count: top level over a chain of sort cells.
// Depends on iscc_pkg and iscc_cell.
//
//   channel | valid      | stall       | fields
//   in      | in_valid_i | in_stall_o  | sample_value_i, is_last_i
//   out     | out_valid_o| out_stall_i | sorted_value_o, end_of_set_o,
//           |            |             | comparison_total_o, overflow_o
//
// An input value is inserted with all cells comparing in parallel.
// On a last item the set of n values drains from cell 0, one per cycle while
// out_stall_i is low; the input stalls until the final value is transferred.
// Output stalls hold the chain; results always come from registers.
// Reset clears the fill count, comparison total, overflow flag and state.
module insertion_sorter_with_comparison_count_core import iscc_pkg::*; #(
  parameter int MAX_ITEMS   = 32,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] sample_value_i,
  input  logic                          is_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [VALUE_WIDTH-1:0] sorted_value_o,
  output logic                          end_of_set_o,
  output logic [SUM_W-1:0]              comparison_total_o,
  output logic                          overflow_o
);

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int PW = $clog2(MAX_ITEMS);

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                          state_q, state_d;
  logic [CW-1:0]                 fill_q, fill_d;
  logic [SUM_W-1:0]              sum_q, sum_d;
  logic                          ovf_q, ovf_d;

  logic                          in_xfer, out_xfer, full, load;
  cell_ctrl_t                    ctrl;
  logic signed [VALUE_WIDTH-1:0] val [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]          gt, ins;
  logic [PW-1:0]                 pos;
  logic [CW-1:0]                 comps;
  logic [SUM_W:0]                sum_ext;

  assign in_stall_o = (state_q == ST_DRAIN);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_DRAIN);
  assign out_xfer   = out_valid_o && !out_stall_i;
  assign full       = (fill_q == CW'(MAX_ITEMS));
  assign load       = in_xfer && !full;

  assign ctrl.load  = load;
  assign ctrl.drain = out_xfer;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] prev_val, next_val;
    logic                          prev_gt;

    if (i == 0) begin : g_head
      assign prev_val = sample_value_i;
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_val = val[i-1];
      assign prev_gt  = gt[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_val = val[i];
    end else begin : g_link
      assign next_val = val[i+1];
    end

    iscc_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (fill_q > CW'(i)),
      .at_fill_i  (fill_q == CW'(i)),
      .sample_i   (sample_value_i),
      .prev_val_i (prev_val),
      .prev_gt_i  (prev_gt),
      .next_val_i (next_val),
      .val_o      (val[i]),
      .gt_o       (gt[i]),
      .ins_o      (ins[i])
    );
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if (ins[i]) begin
        pos = pos | PW'(i);
      end
    end
  end

  assign comps   = (pos == '0) ? fill_q : CW'(fill_q - CW'(pos) + CW'(1));
  assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(comps);

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    sum_d   = sum_q;
    ovf_d   = ovf_q;
    case (state_q)
      ST_FILL: begin
        if (in_xfer) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            fill_d = fill_q + CW'(1);
            sum_d  = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
          end
          if (is_last_i) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_xfer) begin
          fill_d = fill_q - CW'(1);
          if (fill_q == CW'(1)) begin
            state_d = ST_FILL;
            sum_d   = '0;
            ovf_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      fill_q  <= '0;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      sum_q   <= sum_d;
      ovf_q   <= ovf_d;
    end
  end

  assign sorted_value_o     = val[0];
  assign end_of_set_o       = (fill_q == CW'(1));
  assign comparison_total_o = sum_q;
  assign overflow_o         = ovf_q;

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fill_q != '0)
    else $error("drain with empty store");

  a_single_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> $onehot(ins))
    else $error("insert position not unique");

  a_clear_after_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && end_of_set_o) |=> (fill_q == '0 && sum_q == '0 && !ovf_q && !in_stall_o))
    else $error("store not cleared after set");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(MAX_ITEMS))
    else $error("fill count beyond capacity");

endmodule
